// File: sv/assert_macros.svh
// Assertion macros used by the checker in sv/rvdec_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent on the same edge or later.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("implication failed");

`endif

// File: sv/rvdec_pkg.sv
// Types, opcodes and lookup functions for the RV32I instruction decoder.
package rvdec_pkg;

   localparam int WordWidth = 32;
   localparam logic [WordWidth-1:0] UpperMask = 32'hFFFF_F000;

   localparam logic [6:0] OPC_REG    = 7'h33;
   localparam logic [6:0] OPC_IMM    = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [2:0] F3_ARITH = 3'd0;
   localparam logic [2:0] F3_SHR   = 3'd5;

   typedef enum logic [2:0] {
      FMT_NONE = 3'd0,
      FMT_R    = 3'd1,
      FMT_I    = 3'd2,
      FMT_S    = 3'd3,
      FMT_B    = 3'd4,
      FMT_U    = 3'd5,
      FMT_J    = 3'd6
   } format_type;

   typedef enum logic [5:0] {
      OP_NONE     = 6'd0,
      OP_ADD      = 6'd1,
      OP_SUB      = 6'd2,
      OP_SLL      = 6'd3,
      OP_SLT      = 6'd4,
      OP_SLTU     = 6'd5,
      OP_XOR      = 6'd6,
      OP_SRL      = 6'd7,
      OP_SRA      = 6'd8,
      OP_OR       = 6'd9,
      OP_AND      = 6'd10,
      OP_ADDI     = 6'd11,
      OP_SLTI     = 6'd12,
      OP_SLTIU    = 6'd13,
      OP_XORI     = 6'd14,
      OP_ORI      = 6'd15,
      OP_ANDI     = 6'd16,
      OP_SLLI     = 6'd17,
      OP_SRLI     = 6'd18,
      OP_SRAI     = 6'd19,
      OP_LB       = 6'd20,
      OP_LH       = 6'd21,
      OP_LW       = 6'd22,
      OP_LBU      = 6'd23,
      OP_LHU      = 6'd24,
      OP_SB       = 6'd25,
      OP_SH       = 6'd26,
      OP_SW       = 6'd27,
      OP_BEQ      = 6'd28,
      OP_BNE      = 6'd29,
      OP_BLT      = 6'd30,
      OP_BGE      = 6'd31,
      OP_BLTU     = 6'd32,
      OP_BGEU     = 6'd33,
      OP_LUI      = 6'd34,
      OP_UPPER_PC = 6'd35,
      OP_JAL      = 6'd36,
      OP_JALR     = 6'd37
   } op_type;

   function automatic op_type reg_op(input logic [2:0] f3);
      case (f3)
         3'd0: reg_op = OP_ADD;
         3'd1: reg_op = OP_SLL;
         3'd2: reg_op = OP_SLT;
         3'd3: reg_op = OP_SLTU;
         3'd4: reg_op = OP_XOR;
         3'd5: reg_op = OP_SRL;
         3'd6: reg_op = OP_OR;
         3'd7: reg_op = OP_AND;
         default: reg_op = OP_NONE;
      endcase
   endfunction

   function automatic op_type alt_reg_op(input logic [2:0] f3);
      case (f3)
         F3_ARITH: alt_reg_op = OP_SUB;
         F3_SHR:   alt_reg_op = OP_SRA;
         default:  alt_reg_op = OP_NONE;
      endcase
   endfunction

   function automatic op_type imm_op(input logic [2:0] f3);
      case (f3)
         3'd0: imm_op = OP_ADDI;
         3'd1: imm_op = OP_SLLI;
         3'd2: imm_op = OP_SLTI;
         3'd3: imm_op = OP_SLTIU;
         3'd4: imm_op = OP_XORI;
         3'd5: imm_op = OP_SRLI;
         3'd6: imm_op = OP_ORI;
         3'd7: imm_op = OP_ANDI;
         default: imm_op = OP_NONE;
      endcase
   endfunction

   function automatic op_type load_op(input logic [2:0] f3);
      case (f3)
         3'd0: load_op = OP_LB;
         3'd1: load_op = OP_LH;
         3'd2: load_op = OP_LW;
         3'd4: load_op = OP_LBU;
         3'd5: load_op = OP_LHU;
         default: load_op = OP_NONE;
      endcase
   endfunction

   function automatic op_type store_op(input logic [2:0] f3);
      case (f3)
         3'd0: store_op = OP_SB;
         3'd1: store_op = OP_SH;
         3'd2: store_op = OP_SW;
         default: store_op = OP_NONE;
      endcase
   endfunction

   function automatic op_type branch_op(input logic [2:0] f3);
      case (f3)
         3'd0: branch_op = OP_BEQ;
         3'd1: branch_op = OP_BNE;
         3'd4: branch_op = OP_BLT;
         3'd5: branch_op = OP_BGE;
         3'd6: branch_op = OP_BLTU;
         3'd7: branch_op = OP_BGEU;
         default: branch_op = OP_NONE;
      endcase
   endfunction

endpackage

// File: sv/rv32i_instruction_decoder.sv
// RV32I instruction decoder: input register, decode logic, result register.
//
// Usage:
//   Present an instruction word on req_instr_word and raise start. The
//   request is taken at a rising edge where start is high and busy is low.
//   busy is high only while reset is asserted; otherwise a request may be
//   issued on every cycle.
//   Once a request is taken, it passes the input register and then the
//   result register; rsp_strobe is then high for one cycle with the decoded
//   fields, format, immediate, operation and valid flag. Throughput is one
//   instruction per cycle, set by the single pass of decode logic between
//   the two registers.
//   Results come in request order; the receiver cannot stall the result
//   channel, so each result must be taken in its strobe cycle.
//   Synchronous reset clears both valid stages; requests in flight are
//   dropped and no request is taken while reset is high.
module rv32i_instruction_decoder
   import rvdec_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [WordWidth-1:0]        req_instr_word,
   output logic                        rsp_strobe,
   output logic                        rsp_is_valid,
   output logic [2:0]                  rsp_format_code,
   output logic [5:0]                  rsp_operation,
   output logic [6:0]                  rsp_major_opcode,
   output logic [4:0]                  rsp_dest_reg,
   output logic [2:0]                  rsp_func_three,
   output logic [4:0]                  rsp_src_reg_one,
   output logic [4:0]                  rsp_src_reg_two,
   output logic [6:0]                  rsp_func_seven,
   output logic signed [WordWidth-1:0] rsp_immediate
);

   logic                 req_valid_ff;
   logic [WordWidth-1:0] req_word_ff;

   logic                 rsp_valid_ff;
   logic [WordWidth-1:0] rsp_word_ff;
   format_type           rsp_format_ff;
   op_type               rsp_op_ff;
   logic [WordWidth-1:0] rsp_imm_ff;

   format_type           format_in;
   op_type               op_in;
   logic [WordWidth-1:0] imm_in;

   logic [WordWidth-1:0] w;
   logic [6:0]           opc;
   logic [2:0]           f3;
   logic [6:0]           f7;
   logic [WordWidth-1:0] imm_i;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_word_ff <= req_instr_word;
      end
   end

   assign w     = req_word_ff;
   assign opc   = w[6:0];
   assign f3    = w[14:12];
   assign f7    = w[31:25];
   assign imm_i = {{20{w[31]}}, w[31:20]};

   always_comb begin
      format_in = FMT_NONE;
      op_in     = OP_NONE;
      imm_in    = '0;
      case (opc)
         OPC_REG: begin
            format_in = FMT_R;
            op_in     = reg_op(f3);
            if (f3 == F3_ARITH || f3 == F3_SHR) begin
               if (f7 == F7_ALT) begin
                  op_in = alt_reg_op(f3);
               end else if (f7 != F7_BASE) begin
                  op_in = OP_NONE;
               end
            end
         end
         OPC_IMM: begin
            format_in = FMT_I;
            imm_in    = imm_i;
            op_in     = imm_op(f3);
            if (f3 == F3_SHR && w[30]) begin
               op_in = OP_SRAI;
            end
         end
         OPC_LOAD: begin
            format_in = FMT_I;
            imm_in    = imm_i;
            op_in     = load_op(f3);
         end
         OPC_STORE: begin
            format_in = FMT_S;
            imm_in    = {{20{w[31]}}, w[31:25], w[11:7]};
            op_in     = store_op(f3);
         end
         OPC_BRANCH: begin
            format_in = FMT_B;
            imm_in    = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            op_in     = branch_op(f3);
         end
         OPC_LUI: begin
            format_in = FMT_U;
            imm_in    = w & UpperMask;
            op_in     = OP_LUI;
         end
         OPC_AUIPC: begin
            format_in = FMT_U;
            imm_in    = w & UpperMask;
            op_in     = OP_UPPER_PC;
         end
         OPC_JAL: begin
            format_in = FMT_J;
            imm_in    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            op_in     = OP_JAL;
         end
         OPC_JALR: begin
            format_in = FMT_I;
            imm_in    = imm_i;
            op_in     = OP_JALR;
         end
         default: begin
            format_in = FMT_NONE;
            op_in     = OP_NONE;
            imm_in    = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_word_ff   <= req_word_ff;
         rsp_format_ff <= format_in;
         rsp_op_ff     <= op_in;
         rsp_imm_ff    <= imm_in;
      end
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_is_valid     = (rsp_op_ff != OP_NONE);
   assign rsp_format_code  = rsp_format_ff;
   assign rsp_operation    = rsp_op_ff;
   assign rsp_major_opcode = rsp_word_ff[6:0];
   assign rsp_dest_reg     = rsp_word_ff[11:7];
   assign rsp_func_three   = rsp_word_ff[14:12];
   assign rsp_src_reg_one  = rsp_word_ff[19:15];
   assign rsp_src_reg_two  = rsp_word_ff[24:20];
   assign rsp_func_seven   = rsp_word_ff[31:25];
   assign rsp_immediate    = $signed(rsp_imm_ff);

endmodule

// File: sv/rvdec_checker.sv
// Port-level checker for the RV32I instruction decoder, with its bind.
`include "assert_macros.svh"

module rvdec_checker
   import rvdec_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [WordWidth-1:0]        req_instr_word,
   input logic                        rsp_strobe,
   input logic                        rsp_is_valid,
   input logic [2:0]                  rsp_format_code,
   input logic [5:0]                  rsp_operation,
   input logic [6:0]                  rsp_major_opcode,
   input logic [4:0]                  rsp_dest_reg,
   input logic [2:0]                  rsp_func_three,
   input logic [4:0]                  rsp_src_reg_one,
   input logic [4:0]                  rsp_src_reg_two,
   input logic [6:0]                  rsp_func_seven,
   input logic signed [WordWidth-1:0] rsp_immediate
);

   `ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##2 rsp_strobe)
   `ASSERT_IMPLY(a_opcode_passes, clock, reset, start && !busy, ##2 (rsp_major_opcode == $past(req_instr_word[6:0], 2)))
   `ASSERT_IMPLY(a_valid_matches_op, clock, reset, rsp_strobe, (rsp_is_valid == (rsp_operation != OP_NONE)))
   `ASSERT_IMPLY(a_r_format_no_imm, clock, reset, rsp_strobe && rsp_format_code == FMT_R, (rsp_immediate == 0))
   `ASSERT_IMPLY(a_unknown_is_empty, clock, reset, rsp_strobe && rsp_format_code == FMT_NONE, (!rsp_is_valid && rsp_immediate == 0))

endmodule

bind rv32i_instruction_decoder rvdec_checker u_rvdec_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the RV32I instruction decoder: directed table plus random words.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rvdec_pkg::*;

   typedef struct packed {
      logic       valid;
      format_type fmt;
      op_type     op;
      logic [6:0] opc;
      logic [4:0] rd;
      logic [2:0] f3;
      logic [4:0] rs1;
      logic [4:0] rs2;
      logic [6:0] f7;
      logic [31:0] imm;
   } decoded_instr_type;

   typedef struct {
      logic [31:0]       word;
      bit                typed;
      decoded_instr_type want;
   } instr_row_type;

   localparam decoded_instr_type NO_DECODE = '0;
   localparam int RandomPerPhase = 610;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_instr_word;
   logic        rsp_strobe;
   logic        rsp_is_valid;
   logic [2:0]  rsp_format_code;
   logic [5:0]  rsp_operation;
   logic [6:0]  rsp_major_opcode;
   logic [4:0]  rsp_dest_reg;
   logic [2:0]  rsp_func_three;
   logic [4:0]  rsp_src_reg_one;
   logic [4:0]  rsp_src_reg_two;
   logic [6:0]  rsp_func_seven;
   logic signed [31:0] rsp_immediate;

   decoded_instr_type expected_decodes[$];
   instr_row_type     directed_rows[$];
   int                errors = 0;
   int                decoded_count = 0;
   int                valid_count = 0;
   logic [63:0]       ops_seen = '0;

   rv32i_instruction_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_instr_word   (req_instr_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_is_valid     (rsp_is_valid),
      .rsp_format_code  (rsp_format_code),
      .rsp_operation    (rsp_operation),
      .rsp_major_opcode (rsp_major_opcode),
      .rsp_dest_reg     (rsp_dest_reg),
      .rsp_func_three   (rsp_func_three),
      .rsp_src_reg_one  (rsp_src_reg_one),
      .rsp_src_reg_two  (rsp_src_reg_two),
      .rsp_func_seven   (rsp_func_seven),
      .rsp_immediate    (rsp_immediate)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic decoded_instr_type decode_instr(input logic [31:0] w);
      decoded_instr_type d;
      logic [31:0]       i_imm;
      i_imm = {{20{w[31]}}, w[31:20]};
      d.opc = w[6:0];
      d.rd = w[11:7];
      d.f3 = w[14:12];
      d.rs1 = w[19:15];
      d.rs2 = w[24:20];
      d.f7 = w[31:25];
      d.fmt = FMT_NONE;
      d.op = OP_NONE;
      d.imm = '0;
      case (w[6:0])
         OPC_REG: begin
            d.fmt = FMT_R;
            case (w[14:12])
               3'd0: begin
                  if (w[31:25] == F7_BASE) d.op = OP_ADD;
                  else if (w[31:25] == F7_ALT) d.op = OP_SUB;
               end
               3'd1: d.op = OP_SLL;
               3'd2: d.op = OP_SLT;
               3'd3: d.op = OP_SLTU;
               3'd4: d.op = OP_XOR;
               3'd5: begin
                  if (w[31:25] == F7_BASE) d.op = OP_SRL;
                  else if (w[31:25] == F7_ALT) d.op = OP_SRA;
               end
               3'd6: d.op = OP_OR;
               default: d.op = OP_AND;
            endcase
         end
         OPC_IMM: begin
            d.fmt = FMT_I;
            d.imm = i_imm;
            case (w[14:12])
               3'd0: d.op = OP_ADDI;
               3'd1: d.op = OP_SLLI;
               3'd2: d.op = OP_SLTI;
               3'd3: d.op = OP_SLTIU;
               3'd4: d.op = OP_XORI;
               3'd5: begin
                  if (w[30]) d.op = OP_SRAI;
                  else d.op = OP_SRLI;
               end
               3'd6: d.op = OP_ORI;
               default: d.op = OP_ANDI;
            endcase
         end
         OPC_LOAD: begin
            d.fmt = FMT_I;
            d.imm = i_imm;
            case (w[14:12])
               3'd0: d.op = OP_LB;
               3'd1: d.op = OP_LH;
               3'd2: d.op = OP_LW;
               3'd4: d.op = OP_LBU;
               3'd5: d.op = OP_LHU;
               default: d.op = OP_NONE;
            endcase
         end
         OPC_STORE: begin
            d.fmt = FMT_S;
            d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            case (w[14:12])
               3'd0: d.op = OP_SB;
               3'd1: d.op = OP_SH;
               3'd2: d.op = OP_SW;
               default: d.op = OP_NONE;
            endcase
         end
         OPC_BRANCH: begin
            d.fmt = FMT_B;
            d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            case (w[14:12])
               3'd0: d.op = OP_BEQ;
               3'd1: d.op = OP_BNE;
               3'd4: d.op = OP_BLT;
               3'd5: d.op = OP_BGE;
               3'd6: d.op = OP_BLTU;
               3'd7: d.op = OP_BGEU;
               default: d.op = OP_NONE;
            endcase
         end
         OPC_LUI: begin
            d.fmt = FMT_U;
            d.imm = w & UpperMask;
            d.op = OP_LUI;
         end
         OPC_AUIPC: begin
            d.fmt = FMT_U;
            d.imm = w & UpperMask;
            d.op = OP_UPPER_PC;
         end
         OPC_JAL: begin
            d.fmt = FMT_J;
            d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            d.op = OP_JAL;
         end
         OPC_JALR: begin
            d.fmt = FMT_I;
            d.imm = i_imm;
            d.op = OP_JALR;
         end
         default: ;
      endcase
      d.valid = (d.op != OP_NONE);
      return d;
   endfunction

   function automatic logic [31:0] random_instr();
      logic [31:0] w;
      logic [6:0]  known_opc [9];
      int unsigned pick;
      known_opc = '{OPC_REG, OPC_IMM, OPC_LOAD, OPC_STORE, OPC_BRANCH,
                    OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR};
      w = $urandom();
      pick = $urandom_range(99);
      if (pick < 80) begin
         w[6:0] = known_opc[$urandom_range(8)];
         if (w[6:0] == OPC_REG && $urandom_range(3) != 0) begin
            w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
         end
      end else if (pick < 90) begin
         w[1:0] = 2'b11;
      end
      return w;
   endfunction

   task automatic issue(input logic [31:0] w, input bit typed, input decoded_instr_type want,
                        input int unsigned idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_instr_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_decodes.push_back(typed ? want : decode_instr(w));
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      decoded_instr_type want;
      if (rsp_strobe === 1'b1) begin
         if (expected_decodes.size() == 0) begin
            $error("result with no request pending, opcode %h", rsp_major_opcode);
            errors++;
         end else begin
            want = expected_decodes.pop_front();
            check_field("is_valid", want.valid, rsp_is_valid);
            check_field("format_code", want.fmt, rsp_format_code);
            check_field("operation", want.op, rsp_operation);
            check_field("major_opcode", want.opc, rsp_major_opcode);
            check_field("dest_reg", want.rd, rsp_dest_reg);
            check_field("func_three", want.f3, rsp_func_three);
            check_field("src_reg_one", want.rs1, rsp_src_reg_one);
            check_field("src_reg_two", want.rs2, rsp_src_reg_two);
            check_field("func_seven", want.f7, rsp_func_seven);
            check_field("immediate", want.imm, rsp_immediate);
            decoded_count++;
            if (rsp_is_valid === 1'b1) valid_count++;
            ops_seen[rsp_operation] = 1'b1;
         end
      end
   end

   initial begin
      int unsigned idle_pct;
      int unsigned guard;
      reset = 1'b1;
      start = 1'b0;
      req_instr_word = '0;
      directed_rows = '{
         '{32'h0000_0000, 1'b1,
           '{1'b0, FMT_NONE, OP_NONE, 7'h00, 5'h00, 3'h0, 5'h00, 5'h00, 7'h00, 32'h0}},
         '{32'hFFFF_FFFF, 1'b1,
           '{1'b0, FMT_NONE, OP_NONE, 7'h7F, 5'h1F, 3'h7, 5'h1F, 5'h1F, 7'h7F, 32'h0}},
         '{32'h0231_00B3, 1'b1,
           '{1'b0, FMT_R, OP_NONE, 7'h33, 5'h01, 3'h0, 5'h02, 5'h03, 7'h01, 32'h0}},
         '{32'h0000_3003, 1'b1,
           '{1'b0, FMT_I, OP_NONE, 7'h03, 5'h00, 3'h3, 5'h00, 5'h00, 7'h00, 32'h0}},
         '{32'hFFFF_F037, 1'b1,
           '{1'b1, FMT_U, OP_LUI, 7'h37, 5'h00, 3'h7, 5'h1F, 5'h1F, 7'h7F, 32'hFFFF_F000}},
         '{32'h8000_00EF, 1'b1,
           '{1'b1, FMT_J, OP_JAL, 7'h6F, 5'h01, 3'h0, 5'h00, 5'h00, 7'h40, 32'hFFF0_0000}},
         '{32'h8000_0063, 1'b1,
           '{1'b1, FMT_B, OP_BEQ, 7'h63, 5'h00, 3'h0, 5'h00, 5'h00, 7'h40, 32'hFFFF_F000}},
         '{32'h0031_00B3, 1'b0, NO_DECODE},
         '{32'h4031_00B3, 1'b0, NO_DECODE},
         '{32'hFE31_10B3, 1'b0, NO_DECODE},
         '{32'h0031_50B3, 1'b0, NO_DECODE},
         '{32'h4031_50B3, 1'b0, NO_DECODE},
         '{32'h8000_5033, 1'b0, NO_DECODE},
         '{32'hAA00_7033, 1'b0, NO_DECODE},
         '{32'hFFF0_0093, 1'b0, NO_DECODE},
         '{32'hFE00_1013, 1'b0, NO_DECODE},
         '{32'h4000_5013, 1'b0, NO_DECODE},
         '{32'hBE00_5013, 1'b0, NO_DECODE},
         '{32'h8000_2003, 1'b0, NO_DECODE},
         '{32'hFE00_0FA3, 1'b0, NO_DECODE},
         '{32'h0000_3023, 1'b0, NO_DECODE},
         '{32'h7E00_7FE3, 1'b0, NO_DECODE},
         '{32'h0000_2063, 1'b0, NO_DECODE},
         '{32'h0000_1017, 1'b0, NO_DECODE},
         '{32'h7FFF_F06F, 1'b0, NO_DECODE},
         '{32'hFFF0_7067, 1'b0, NO_DECODE}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         issue(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want, 17);
      end
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 17 : (phase == 1) ? 78 : 0;
         repeat (RandomPerPhase) issue(random_instr(), 1'b0, NO_DECODE, idle_pct);
      end
      start <= 1'b0;
      guard = 0;
      while (expected_decodes.size() != 0 && guard < 100) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (expected_decodes.size() != 0) begin
         $error("%0d requests never produced a result", expected_decodes.size());
         errors++;
      end
      $display("checked %0d decodes: %0d valid, %0d rejected", decoded_count, valid_count,
               decoded_count - valid_count);
      $display("operations seen: %0d of 37, over three sender idle profiles",
               $countones(ops_seen[37:1]));
      if (errors == 0) begin
         $display("rv32i_instruction_decoder regression: pass");
      end else begin
         $display("rv32i_instruction_decoder regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("rv32i_instruction_decoder regression: fail");
      $finish;
   end

endmodule

// File: rv32i_instruction_decoder.f
+incdir+sv
sv/rvdec_pkg.sv
sv/rv32i_instruction_decoder.sv
sv/rvdec_checker.sv
tb/tb_top.sv
